### rtl/core/assert_macros.svh
// assertion macros shared by the coder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define MFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define MFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/mfbae_pkg.sv
// constants shared by the binary arithmetic coder modules
package mfbae_pkg;
  localparam int unsigned CTX_AW      = 8;
  localparam int unsigned CTX_DEPTH   = 256;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned DIVIDEND_W  = 16;
  localparam int unsigned DIVISOR_W   = 10;
  localparam int unsigned QUOT_W      = 8;

  localparam logic [7:0]  SPLIT_SCALE   = 8'd175;
  localparam logic [23:0] LOW_MASK      = 24'hFFFFFF;
  localparam logic [7:0]  HALF_COUNT    = 8'd127;
  localparam logic [5:0]  COUNTER_START = 6'b101000;
  localparam logic [5:0]  COUNTER_RELOAD = 6'b111000;
  localparam logic [7:0]  RANGE_MIN     = 8'd128;
  localparam logic [7:0]  RANGE_START   = 8'd255;
  localparam logic [3:0]  MAX_DATA_BYTES = 4'd8;
endpackage

### rtl/core/multiply_free_binary_arith_encoder_top.sv
// binary arithmetic coder top level with bit sequencer
// each bit passes the read, split, divide, update and renormalise states; a final byte adds the flush.
// bytes are taken one at a time, only while the sequencer is idle.
// a stalled output word holds the sequencer when a new word is produced or the last one is passed on.
// reset: asynchronous, active low; clears all context counts and the coder.
`include "assert_macros.svh"
module multiply_free_binary_arith_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] code_byte_o,
  output logic       last_of_run_o,
  output logic       end_of_stream_o
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_CALC, ST_DIV, ST_UPD, ST_RENORM, ST_FSH, ST_FBYTE, ST_DONE
  } state_e;

  state_e      state_q;
  logic [7:0]  byte_q;
  logic        fin_q;
  logic [7:0]  node_q;
  logic [2:0]  bitcnt_q;
  logic [3:0]  emitted_q;
  logic [7:0]  range_q;
  logic [31:0] low_q;
  logic [5:0]  cnt_q;
  logic [7:0]  z_q;
  logic [7:0]  o_q;
  logic        lesser_q;
  logic [1:0]  fk_q;
  logic        pend_v_q;
  logic [7:0]  pend_byte_q;
  logic        pend_eos_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_eos_q;

  logic [15:0] rd_data;
  logic        div_start;
  logic        div_done;
  logic [7:0]  quot;
  logic [7:0]  z_rd;
  logic [7:0]  o_rd;
  logic        lesser_rd;
  logic [8:0]  num_rd;
  logic [15:0] dividend;
  logic [9:0]  divisor;
  logic        cur_bit;
  logic [7:0]  m;
  logic [7:0]  bz;
  logic [7:0]  bo;
  logic        wr_en;
  logic [7:0]  rng2;
  logic [31:0] low2;
  logic [5:0]  cnt2;
  logic [23:0] diff;
  logic [7:0]  rng_cl;
  logic        slot_free;
  logic        do_emit;
  logic        out_load;
  logic [3:0]  sh;
  logic [7:0]  flush_byte;

  // split numerator and denominator from the fetched counts
  always_comb begin
    z_rd      = rd_data[15:8];
    o_rd      = rd_data[7:0];
    lesser_rd = !(z_rd < o_rd);
    num_rd    = lesser_rd ? ({1'b0, o_rd} + 9'd1) : ({1'b0, z_rd} + 9'd1);
    dividend  = 16'({7'b0, num_rd} * {8'b0, mfbae_pkg::SPLIT_SCALE});
    divisor   = {2'b0, z_rd} + {2'b0, o_rd} + 10'd2;
    div_start = (state_q == ST_CALC);
  end

  // split, count update and one doubling step
  always_comb begin
    cur_bit = byte_q[bitcnt_q];
    m       = (quot == 8'd0) ? 8'd1 : quot;
    bz      = z_q;
    bo      = o_q;
    if (!cur_bit) begin
      if (z_q != 8'd255) begin
        bz = z_q + 8'd1;
      end else begin
        bz = mfbae_pkg::HALF_COUNT;
        bo = o_q >> 1;
      end
    end else begin
      if (o_q != 8'd255) begin
        bo = o_q + 8'd1;
      end else begin
        bo = mfbae_pkg::HALF_COUNT;
        bz = z_q >> 1;
      end
    end
    wr_en  = (state_q == ST_UPD);
    rng2   = {range_q[6:0], 1'b0};
    low2   = {low_q[30:0], 1'b0};
    cnt2   = cnt_q + 6'd1;
    diff   = mfbae_pkg::LOW_MASK - low2[23:0];
    rng_cl = (diff < {16'b0, rng2}) ? diff[7:0] : rng2;
    if (rng_cl == 8'd0) begin
      rng_cl = 8'd1;
    end
    do_emit    = (emitted_q < mfbae_pkg::MAX_DATA_BYTES);
    slot_free  = !pend_v_q || !out_valid_q || out_ready_i;
    // pending word moves to the output register
    out_load   = pend_v_q && (!out_valid_q || out_ready_i) &&
                 (((state_q == ST_RENORM) && (range_q < mfbae_pkg::RANGE_MIN) &&
                   (cnt2 == 6'd0) && do_emit) ||
                  (state_q == ST_FBYTE) || (state_q == ST_DONE));
    sh         = 4'd8 - {1'b0, cnt_q[2:0]};
    flush_byte = low_q[31:24];
    case (fk_q)
      2'd0:    flush_byte = low_q[31:24];
      2'd1:    flush_byte = low_q[23:16];
      2'd2:    flush_byte = low_q[15:8];
      default: flush_byte = low_q[7:0];
    endcase
  end

  // sequencer, coder registers and output words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      byte_q      <= '0;
      fin_q       <= 1'b0;
      node_q      <= 8'd1;
      bitcnt_q    <= 3'd7;
      emitted_q   <= '0;
      range_q     <= mfbae_pkg::RANGE_START;
      low_q       <= '0;
      cnt_q       <= mfbae_pkg::COUNTER_START;
      z_q         <= '0;
      o_q         <= '0;
      lesser_q    <= 1'b0;
      fk_q        <= '0;
      pend_v_q    <= 1'b0;
      pend_byte_q <= '0;
      pend_eos_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      out_eos_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            byte_q    <= data_byte_i;
            fin_q     <= final_req_i;
            node_q    <= 8'd1;
            bitcnt_q  <= 3'd7;
            emitted_q <= '0;
            state_q   <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          z_q      <= z_rd;
          o_q      <= o_rd;
          lesser_q <= lesser_rd;
          state_q  <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (cur_bit == lesser_q) begin
            low_q   <= low_q + {24'b0, range_q - m};
            range_q <= m;
          end else begin
            range_q <= range_q - m;
          end
          node_q  <= {node_q[6:0], cur_bit};
          state_q <= ST_RENORM;
        end
        ST_RENORM: begin
          if (range_q < mfbae_pkg::RANGE_MIN) begin
            if (cnt2 != 6'd0) begin
              range_q <= rng2;
              low_q   <= low2;
              cnt_q   <= cnt2;
            end else if (!do_emit || slot_free) begin
              cnt_q   <= mfbae_pkg::COUNTER_RELOAD;
              low_q   <= {8'b0, low2[23:0]};
              range_q <= rng_cl;
              if (do_emit) begin
                emitted_q <= emitted_q + 4'd1;
                if (pend_v_q) begin
                  out_byte_q  <= pend_byte_q;
                  out_last_q  <= 1'b0;
                  out_eos_q   <= pend_eos_q;
                end
                pend_v_q    <= 1'b1;
                pend_byte_q <= low2[31:24];
                pend_eos_q  <= 1'b0;
              end
            end
          end else if (bitcnt_q == 3'd0) begin
            fk_q    <= '0;
            state_q <= fin_q ? ST_FSH : ST_DONE;
          end else begin
            bitcnt_q <= bitcnt_q - 3'd1;
            state_q  <= ST_READ;
          end
        end
        ST_FSH: begin
          low_q   <= low_q << sh;
          state_q <= ST_FBYTE;
        end
        ST_FBYTE: begin
          if (slot_free) begin
            if (pend_v_q) begin
              out_byte_q  <= pend_byte_q;
              out_last_q  <= 1'b0;
              out_eos_q   <= pend_eos_q;
            end
            pend_v_q    <= 1'b1;
            pend_byte_q <= flush_byte;
            pend_eos_q  <= (fk_q == 2'd3);
            fk_q        <= fk_q + 2'd1;
            if (fk_q == 2'd3) begin
              range_q <= mfbae_pkg::RANGE_START;
              low_q   <= '0;
              cnt_q   <= mfbae_pkg::COUNTER_START;
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (!out_valid_q || out_ready_i) begin
            out_byte_q  <= pend_byte_q;
            out_last_q  <= 1'b1;
            out_eos_q   <= pend_eos_q;
            pend_v_q    <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // context store and shared divider
  mfbae_ctx u_ctx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (state_q == ST_READ),
    .rd_addr_i (node_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (node_q),
    .wr_data_i ({bz, bo})
  );

  mfbae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign code_byte_o     = out_byte_q;
  assign last_of_run_o   = out_last_q;
  assign end_of_stream_o = out_eos_q;

  `MFB_ASSERT(a_idle_no_pend, (state_q == ST_IDLE) |-> !pend_v_q, "word left pending at idle")
  `MFB_ASSERT(a_idle_range, (state_q == ST_IDLE) |-> range_q[7], "range not normalised at idle")
  `MFB_ASSERT(a_emit_cap, emitted_q <= mfbae_pkg::MAX_DATA_BYTES, "too many data words")
  `MFB_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "output valid in reset")
endmodule

### rtl/core/mfbae_div.sv
// shared restoring divider, one quotient bit a cycle
`include "assert_macros.svh"
module mfbae_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [mfbae_pkg::DIVIDEND_W-1:0]    dividend_i,
  input  logic [mfbae_pkg::DIVISOR_W-1:0]     divisor_i,
  output logic                                done_o,
  output logic [mfbae_pkg::QUOT_W-1:0]        quot_o
);
  localparam int unsigned DSH_W = mfbae_pkg::DIVISOR_W + mfbae_pkg::QUOT_W - 1;

  logic [mfbae_pkg::DIVIDEND_W-1:0] rem_q;
  logic [DSH_W-1:0]                 dsh_q;
  logic [mfbae_pkg::QUOT_W-1:0]     quot_q;
  logic [2:0]                       step_q;
  logic                             busy_q;
  logic                             done_q;
  logic                             ge;
  logic [DSH_W-1:0]                 rem_ext;
  logic [DSH_W-1:0]                 rem_sub;

  // compare and subtract against the shifted divisor
  always_comb begin
    rem_ext = DSH_W'(rem_q);
    ge      = rem_ext >= dsh_q;
    rem_sub = rem_ext - dsh_q;
  end

  // iteration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
      rem_q  <= '0;
      dsh_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd7;
        rem_q  <= dividend_i;
        dsh_q  <= {divisor_i, 7'b0};
        quot_q <= '0;
      end else if (busy_q) begin
        quot_q <= {quot_q[mfbae_pkg::QUOT_W-2:0], ge};
        if (ge) begin
          rem_q <= rem_sub[mfbae_pkg::DIVIDEND_W-1:0];
        end
        dsh_q <= dsh_q >> 1;
        step_q <= step_q - 3'd1;
        if (step_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  `MFB_ASSERT(a_quot_bound, done_q |-> (quot_q <= mfbae_pkg::SPLIT_SCALE), "split above scale")
endmodule

### rtl/core/mfbae_ctx.sv
// context count store with per-entry valid bits
module mfbae_ctx (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [mfbae_pkg::CTX_AW-1:0]     rd_addr_i,
  output logic [mfbae_pkg::CNT_W-1:0]      rd_data_o,
  input  logic                             wr_en_i,
  input  logic [mfbae_pkg::CTX_AW-1:0]     wr_addr_i,
  input  logic [mfbae_pkg::CNT_W-1:0]      wr_data_i
);
  logic [mfbae_pkg::CNT_W-1:0] mem_q [mfbae_pkg::CTX_DEPTH];
  logic [mfbae_pkg::CTX_DEPTH-1:0] vld_q;
  logic [mfbae_pkg::CNT_W-1:0] rdata_q;
  logic                        rvld_q;

  // memory array, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // unwritten entries read as zero counts
  assign rd_data_o = rvld_q ? rdata_q : '0;
endmodule

### bench/encoder_checker.sv
// checker for the binary arithmetic coder: predicts code words and compares them
`timescale 1ns / 100ps
module encoder_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic       final_req_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] code_byte_i,
  input  logic       last_of_run_i,
  input  logic       end_of_stream_i,
  output int         fail_count_o,
  output int         pending_o
);
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       eos;
  } code_word_t;

  logic [15:0] node_counts [256];
  logic [7:0]  coder_range;
  logic [31:0] coder_low;
  int          shift_count;
  code_word_t  expected_words [$];

  assign pending_o = expected_words.size();

  // work out the code words that one plain byte yields
  task automatic encode_byte(input logic [7:0] plain, input logic fin);
    int unsigned node, z, o, lesser, num, m, bit_v, rng, sh;
    int          emitted;
    code_word_t  words [$];
    code_word_t  w;
    node = 1;
    emitted = 0;
    rng = coder_range;
    for (int b = 7; b >= 0; b--) begin
      bit_v = plain[b];
      z = node_counts[node[7:0]][15:8];
      o = node_counts[node[7:0]][7:0];
      lesser = (z < o) ? 0 : 1;
      num = (lesser == 0) ? z + 1 : o + 1;
      m = (175 * num) / (z + o + 2);
      if (m == 0) m = 1;
      if (bit_v == lesser) begin
        coder_low = coder_low + (rng - m);
        rng = m;
      end else begin
        rng = rng - m;
      end
      rng = rng & 8'hFF;
      // count update with halving at saturation
      if (bit_v == 0) begin
        if (z != 255) z++;
        else begin
          z = 127;
          o = o >> 1;
        end
      end else begin
        if (o != 255) o++;
        else begin
          o = 127;
          z = z >> 1;
        end
      end
      node_counts[node[7:0]] = {z[7:0], o[7:0]};
      node = (node << 1) | bit_v;
      // renormalise
      while (rng < 128) begin
        rng = (rng << 1) & 8'hFF;
        coder_low = coder_low << 1;
        shift_count++;
        if (shift_count == 0) begin
          shift_count = -8;
          if (emitted < 8) begin
            w = '{code: coder_low[31:24], last: 1'b0, eos: 1'b0};
            words.push_back(w);
            emitted++;
          end
          coder_low = coder_low & 32'h00FF_FFFF;
          if (32'h00FF_FFFF - coder_low < rng) rng = 32'h00FF_FFFF - coder_low;
          if (rng == 0) rng = 1;
        end
      end
    end
    coder_range = rng[7:0];
    if (fin) begin
      sh = 8 - (shift_count & 7);
      coder_low = coder_low << sh;
      for (int k = 3; k >= 0; k--) begin
        w = '{code: coder_low[8*k +: 8], last: 1'b0, eos: (k == 0)};
        words.push_back(w);
      end
      coder_range = 8'd255;
      coder_low = '0;
      shift_count = -24;
    end
    if (words.size() > 0) words[words.size()-1].last = 1'b1;
    foreach (words[i]) expected_words.push_back(words[i]);
  endtask

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    code_word_t want;
    if (!rst_ni) begin
      foreach (node_counts[i]) node_counts[i] = '0;
      coder_range = 8'd255;
      coder_low = '0;
      shift_count = -24;
      expected_words.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word code=%h last=%b eos=%b", $time,
                   code_byte_i, last_of_run_i, end_of_stream_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_words.pop_front();
          if (want != {code_byte_i, last_of_run_i, end_of_stream_i}) begin
            $display("%0t: mismatch expected code=%h last=%b eos=%b, got code=%h last=%b eos=%b",
                     $time, want.code, want.last, want.eos, code_byte_i, last_of_run_i,
                     end_of_stream_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) encode_byte(data_byte_i, final_req_i);
    end
  end
endmodule

### bench/testbench.sv
// top of the coder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module testbench;
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b1;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic       final_req_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] code_byte_o;
  logic       last_of_run_o;
  logic       end_of_stream_o;
  int         fail_count;
  int         pending;
  bit         hold_output = 1'b0;
  int         idle_cycles = 0;

  localparam int IDLE_LIMIT = 20000;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  multiply_free_binary_arith_encoder_top dut (.*);

  encoder_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .data_byte_i, .final_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .code_byte_i(code_byte_o),
    .last_of_run_i(last_of_run_o), .end_of_stream_i(end_of_stream_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one word and wait for it to be taken
  task automatic send_byte(input logic [7:0] plain, input logic fin);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    data_byte_i <= plain;
    final_req_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_gapped(input logic [7:0] plain, input logic fin, input bit steady);
    int g;
    g = steady ? 0 : gap_length();
    repeat (g) @(negedge clk_i);
    send_byte(plain, fin);
  endtask

  // receiver readiness, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_output) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) < 70);
  end

  // watchdog on accepted words
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    int len;
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, repeated zero bytes, flush cases
    send_gapped(8'h00, 1'b0, 1'b0);
    send_gapped(8'hFF, 1'b0, 1'b0);
    send_gapped(8'hAA, 1'b0, 1'b0);
    send_gapped(8'h55, 1'b1, 1'b0);
    send_gapped(8'h80, 1'b1, 1'b0);
    send_gapped(8'h01, 1'b0, 1'b1);
    send_gapped(8'h7F, 1'b0, 1'b1);
    for (int i = 0; i < 14; i++) send_gapped(8'h00, (i == 13), 1'b1);
    // sender pause until all words are back
    wait (pending == 0);
    repeat (200) @(negedge clk_i);
    // long receiver hold-off while bytes keep coming
    fork
      begin
        hold_output = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_output = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_gapped(8'($urandom_range(0, 255)), (i % 7 == 6), 1'b1);
    join
    // random messages, contents skewed toward zero and all-ones bytes
    for (int i = 0; i < 280; i += len) begin
      len = $urandom_range(1, 30);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 3))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_gapped(b, (k == len - 1) && ($urandom_range(0, 9) != 0), i > 140 && i < 180);
      end
    end
    send_gapped(8'h3C, 1'b1, 1'b0);
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mfbae_pkg.sv
rtl/core/mfbae_div.sv
rtl/core/mfbae_ctx.sv
rtl/core/multiply_free_binary_arith_encoder_top.sv
bench/encoder_checker.sv
bench/testbench.sv
